### design/bat_pkg.sv
package bat_pkg;

	typedef enum logic [2:0] {
		ACT_READ  = 3'd0,
		ACT_WRITE = 3'd1,
		ACT_INSTR = 3'd2,
		ACT_JUMP  = 3'd3,
		ACT_QUERY = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN
	} back_state_t;

	localparam logic [0:0] CFG_TRACK  = 1'b0;
	localparam logic [0:0] CFG_RECORD = 1'b1;

	localparam logic [15:0] SND_LO = 16'hD400;
	localparam logic [15:0] SND_HI = 16'hD7FF;
	localparam logic [15:0] TMR_LO = 16'hDC04;
	localparam logic [15:0] TMR_HI = 16'hDC05;

	localparam logic [4:0] FL_EXEC   = 5'h01;
	localparam logic [4:0] FL_READ   = 5'h02;
	localparam logic [4:0] FL_WRITE  = 5'h04;
	localparam logic [4:0] FL_JUMP   = 5'h08;
	localparam logic [4:0] FL_OPCODE = 5'h10;

	localparam int SLOT_MAX = 32;

	typedef struct packed {
		action_t     act;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        in_zp;
		logic        zp_byte;
		logic        in_snd;
		logic        tmr_lo;
		logic        tmr_hi;
	} item_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	typedef struct packed {
		logic        sequence_event;
		logic        timer_written;
		logic [7:0]  timer_high;
		logic [7:0]  timer_low;
		logic [15:0] slot_base;
		logic [5:0]  slots_used;
		logic [31:0] zero_page_total;
		logic [31:0] sound_total;
		logic [31:0] sound_reg_count;
		logic [31:0] zero_page_count;
		logic [15:0] writer_address;
		logic [4:0]  access_flags;
	} result_t;

endpackage

### design/bat_front.sv
module bat_front #(
	parameter int ZERO_PAGE_SIZE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,
	input  bat_pkg::back_ctl_t ctl,
	output logic               head_valid,
	output bat_pkg::item_t     head
);
	import bat_pkg::*;

	item_t       q_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	item_t       in_item;
	logic        push;

	always_comb begin
		in_item.act     = action_t'(s_tdata[2:0]);
		in_item.addr    = s_tdata[18:3];
		in_item.data    = s_tdata[26:19];
		in_item.in_zp   = 17'(s_tdata[18:3]) < 17'(ZERO_PAGE_SIZE);
		in_item.zp_byte = 9'(s_tdata[10:3]) < 9'(ZERO_PAGE_SIZE);
		in_item.in_snd  = (s_tdata[18:3] >= SND_LO) && (s_tdata[18:3] <= SND_HI);
		in_item.tmr_lo  = s_tdata[18:3] == TMR_LO;
		in_item.tmr_hi  = s_tdata[18:3] == TMR_HI;
	end

	assign s_tready   = (cnt_q != 2'd2) && !ctl.clearing;
	assign push       = s_tvalid && s_tready;
	assign head_valid = cnt_q != 2'd0;
	assign head       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (ctl.pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(ctl.pop);
		end
	end

endmodule

### design/bat_back.sv
module bat_back #(
	parameter int ADDRESS_SPACE  = 65536,
	parameter int ZERO_PAGE_SIZE = 256,
	parameter int SOUND_SLOTS    = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               track,
	input  logic               record,
	input  logic               head_valid,
	input  bat_pkg::item_t     head,
	output bat_pkg::back_ctl_t ctl,
	output logic               out_valid,
	input  logic               out_ready,
	output bat_pkg::result_t   res
);
	import bat_pkg::*;

	localparam int AW  = $clog2(ADDRESS_SPACE);
	localparam int ZAW = $clog2(ZERO_PAGE_SIZE);

	logic [4:0]  flag_mem [ADDRESS_SPACE];
	logic [15:0] wr_mem   [ADDRESS_SPACE];
	logic [31:0] zp_mem   [ZERO_PAGE_SIZE];

	logic [4:0]  flag_rd_q;
	logic [15:0] wr_rd_q;
	logic [31:0] zp_rd_q;

	back_state_t st_q, st_d;
	item_t       cur_q;
	result_t     res_q;
	logic        out_v_q;
	logic [AW-1:0] clr_q;
	logic [31:0] sreg_q [SLOT_MAX];
	logic [SLOT_MAX-1:0] slot_q;
	logic [5:0]  slots_q;
	logic [31:0] snd_tot_q, zp_tot_q;
	logic [15:0] instr_q;
	logic [7:0]  tlo_q, thi_q;
	logic        tseen_q;
	logic [4:0]  scan_idx_q;
	logic [5:0]  seen_q;

	logic        pop, upd, clr_last, scan_hit, scan_end;
	logic        do_wr, snd_wr, zp_wr, slot_new;
	logic [4:0]  fl_set, fl_new;
	logic        fl_we, wr_we, zp_we;
	logic [AW-1:0]  f_wa;
	logic [4:0]     f_wd;
	logic [15:0]    w_wd;
	logic [ZAW-1:0] z_wa;
	logic [31:0]    z_wd, zp_cnt_nx, sreg_nx;
	logic [4:0]  slot_idx;
	result_t     res_nx;

	assign clr_last  = clr_q == AW'(ADDRESS_SPACE - 1);
	assign pop       = (st_q == ST_IDLE) && head_valid && (!out_v_q || out_ready);
	assign upd       = st_q == ST_UPDATE;
	assign ctl.pop      = pop;
	assign ctl.clearing = st_q == ST_CLEAR;
	assign out_valid = out_v_q;
	assign res       = res_q;

	assign do_wr    = upd && track && (cur_q.act == ACT_WRITE);
	assign snd_wr   = do_wr && cur_q.in_snd;
	assign zp_wr    = do_wr && cur_q.in_zp;
	assign slot_idx = cur_q.addr[9:5];
	assign slot_new = snd_wr && (6'(slot_idx) < 6'(SOUND_SLOTS)) && !slot_q[slot_idx];
	assign scan_hit = slot_q[scan_idx_q] && (8'(seen_q) == cur_q.data);
	assign scan_end = scan_idx_q == 5'(SLOT_MAX - 1);

	always_comb begin
		fl_set = 5'd0;
		if (track) begin
			case (cur_q.act)
				ACT_READ:  fl_set = FL_READ;
				ACT_WRITE: fl_set = FL_WRITE;
				ACT_INSTR: fl_set = FL_EXEC | FL_OPCODE;
				ACT_JUMP:  fl_set = FL_JUMP;
				default:   fl_set = 5'd0;
			endcase
		end
	end

	assign fl_new    = flag_rd_q | fl_set;
	assign zp_cnt_nx = zp_rd_q + 32'(zp_wr);
	assign sreg_nx   = sreg_q[cur_q.addr[4:0]] + 32'(snd_wr);

	always_comb begin
		res_nx.access_flags    = fl_new;
		res_nx.writer_address  = do_wr ? instr_q : wr_rd_q;
		res_nx.zero_page_count = cur_q.zp_byte ? zp_cnt_nx : 32'd0;
		res_nx.sound_reg_count = sreg_nx;
		res_nx.sound_total     = snd_tot_q + 32'(snd_wr);
		res_nx.zero_page_total = zp_tot_q + 32'(zp_wr);
		res_nx.slots_used      = slots_q + 6'(slot_new);
		res_nx.slot_base       = 16'd0;
		res_nx.timer_low       = (do_wr && cur_q.tmr_lo) ? cur_q.data : tlo_q;
		res_nx.timer_high      = (do_wr && cur_q.tmr_hi) ? cur_q.data : thi_q;
		res_nx.timer_written   = tseen_q || (do_wr && (cur_q.tmr_lo || cur_q.tmr_hi));
		res_nx.sequence_event  = snd_wr && record;
	end

	always_comb begin
		if (st_q == ST_CLEAR) begin
			fl_we = 1'b1;
			wr_we = 1'b1;
			zp_we = (AW + 1)'(clr_q) < (AW + 1)'(ZERO_PAGE_SIZE);
			f_wa  = clr_q;
			f_wd  = 5'd0;
			w_wd  = 16'd0;
			z_wa  = clr_q[ZAW-1:0];
			z_wd  = 32'd0;
		end else begin
			fl_we = upd && (fl_set != 5'd0);
			wr_we = do_wr;
			zp_we = zp_wr;
			f_wa  = cur_q.addr[AW-1:0];
			f_wd  = fl_new;
			w_wd  = instr_q;
			z_wa  = cur_q.addr[ZAW-1:0];
			z_wd  = zp_cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (fl_we) begin
			flag_mem[f_wa] <= f_wd;
		end
		if (wr_we) begin
			wr_mem[f_wa] <= w_wd;
		end
		if (zp_we) begin
			zp_mem[z_wa] <= z_wd;
		end
		flag_rd_q <= flag_mem[head.addr[AW-1:0]];
		wr_rd_q   <= wr_mem[head.addr[AW-1:0]];
		zp_rd_q   <= zp_mem[head.addr[ZAW-1:0]];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR:  st_d = clr_last ? ST_IDLE : ST_CLEAR;
			ST_IDLE:   st_d = pop ? ST_UPDATE : ST_IDLE;
			ST_UPDATE: st_d = (cur_q.act == ACT_QUERY) ? ST_SCAN : ST_IDLE;
			ST_SCAN:   st_d = (scan_hit || scan_end) ? ST_IDLE : ST_SCAN;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (upd) begin
			res_q <= res_nx;
		end else if (st_q == ST_SCAN && scan_hit) begin
			res_q.slot_base <= SND_LO | {6'd0, scan_idx_q, 5'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			clr_q      <= '0;
			out_v_q    <= 1'b0;
			slot_q     <= '0;
			slots_q    <= 6'd0;
			snd_tot_q  <= 32'd0;
			zp_tot_q   <= 32'd0;
			instr_q    <= 16'd0;
			tlo_q      <= 8'd0;
			thi_q      <= 8'd0;
			tseen_q    <= 1'b0;
			scan_idx_q <= 5'd0;
			seen_q     <= 6'd0;
			for (int i = 0; i < SLOT_MAX; i++) begin
				sreg_q[i] <= 32'd0;
			end
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if ((upd && cur_q.act != ACT_QUERY) ||
			    (st_q == ST_SCAN && (scan_hit || scan_end))) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (upd) begin
				sreg_q[cur_q.addr[4:0]] <= sreg_nx;
				snd_tot_q <= res_nx.sound_total;
				zp_tot_q  <= res_nx.zero_page_total;
				slots_q   <= res_nx.slots_used;
				tlo_q     <= res_nx.timer_low;
				thi_q     <= res_nx.timer_high;
				tseen_q   <= res_nx.timer_written;
				if (slot_new) begin
					slot_q[slot_idx] <= 1'b1;
				end
				if (cur_q.act == ACT_INSTR) begin
					instr_q <= cur_q.addr;
				end
				scan_idx_q <= 5'd0;
				seen_q     <= 6'd0;
			end else if (st_q == ST_SCAN) begin
				scan_idx_q <= scan_idx_q + 5'd1;
				seen_q     <= seen_q + 6'(slot_q[scan_idx_q]);
			end
		end
	end

endmodule

### design/bus_access_tracker_top.sv
// Bus access tracker: watches one processor bus transaction per input item
// (read, write, instruction start, jump target, query) and answers each with
// one result holding the access flags, last writer, write counters, used
// sound slots and timer latches as they stand after that transaction.
// Input: s_tvalid/s_tready/s_tdata. Output: m_tvalid/m_tready/m_tdata.
// Config: cfg_we/cfg_index/cfg_data; index 0 tracking enable, 1 record enable.
// A two-entry queue parts the input classifier from the execution unit, and
// a result register parts the execution unit from the output, so input keeps
// flowing while a result waits.
// In the execution unit each item first gets its registered table reads, then
// its update and write-back. A query then scans the used slot bits one per
// cycle, up to the first hit or the last slot. The unit takes the next item
// only when it is back in idle and the result register is free.
// After reset the flag and writer tables (and zero-page counters) are cleared
// one entry per cycle, with s_tready low until all ADDRESS_SPACE entries are done.
// When m_tready is low the result is held, the execution unit waits, and the
// input side stalls once the queue is full.
module bus_access_tracker_top #(
	parameter int ADDRESS_SPACE  = 65536,
	parameter int ZERO_PAGE_SIZE = 256,
	parameter int SOUND_SLOTS    = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // action[2:0], address[18:3], value[26:19]
	output logic         m_tvalid,
	input  logic         m_tready,
	// access_flags[4:0], writer_address[20:5], zero_page_count[52:21],
	// sound_reg_count[84:53], sound_total[116:85], zero_page_total[148:117],
	// slots_used[154:149], slot_base[170:155], timer_low[178:171],
	// timer_high[186:179], timer_written[187], sequence_event[188]
	output logic [191:0] m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic         cfg_data
);
	import bat_pkg::*;

	logic      track_q, record_q;
	logic      head_valid;
	item_t     head;
	back_ctl_t ctl;
	result_t   res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q  <= 1'b0;
			record_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRACK:  track_q  <= cfg_data;
				CFG_RECORD: record_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	bat_front #(
		.ZERO_PAGE_SIZE(ZERO_PAGE_SIZE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.ctl       (ctl),
		.head_valid(head_valid),
		.head      (head)
	);

	bat_back #(
		.ADDRESS_SPACE (ADDRESS_SPACE),
		.ZERO_PAGE_SIZE(ZERO_PAGE_SIZE),
		.SOUND_SLOTS   (SOUND_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.track     (track_q),
		.record    (record_q),
		.head_valid(head_valid),
		.head      (head),
		.ctl       (ctl),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {3'd0, res};

endmodule

### tb/sv/tb_top.sv
module tb_top;
	import bat_pkg::*;

	localparam int CYCLE_LIMIT = 1200000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic         cfg_we;
	logic         cfg_index;
	logic         cfg_data;

	bus_access_tracker_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// tracker shadow state
	logic [4:0]  flags_m [int];
	logic [15:0] writer_m [int];
	logic [31:0] zp_cnt [256];
	logic [31:0] snd_cnt [32];
	logic [31:0] slot_bits;
	logic [31:0] snd_total;
	logic [31:0] zp_total;
	logic [15:0] cur_instr;
	logic [7:0]  tmr_lo_q;
	logic [7:0]  tmr_hi_q;
	logic        tmr_seen;
	logic        track_en;
	logic        record_en;

	result_t pending_results[$];
	int      errors = 0;
	longint  cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL bus_access_tracker_top");
			$finish;
		end
	end

	function automatic logic [4:0] flags_at(logic [15:0] a);
		return flags_m.exists(a) ? flags_m[a] : 5'd0;
	endfunction

	function automatic logic [15:0] writer_at(logic [15:0] a);
		return writer_m.exists(a) ? writer_m[a] : 16'd0;
	endfunction

	function automatic result_t track_event(action_t act, logic [15:0] a, logic [7:0] v);
		result_t r;
		int seen;
		r = '0;
		case (act)
			ACT_READ: if (track_en) flags_m[a] = flags_at(a) | FL_READ;
			ACT_WRITE: if (track_en) begin
				flags_m[a] = flags_at(a) | FL_WRITE;
				writer_m[a] = cur_instr;
				if (a < 16'h0100) begin
					zp_cnt[a[7:0]]++;
					zp_total++;
				end
				if (a >= SND_LO && a <= SND_HI) begin
					snd_cnt[a[4:0]]++;
					snd_total++;
					slot_bits[(a - SND_LO) >> 5] = 1'b1;
					r.sequence_event = record_en;
				end
				if (a == TMR_LO) begin
					tmr_lo_q = v;
					tmr_seen = 1'b1;
				end else if (a == TMR_HI) begin
					tmr_hi_q = v;
					tmr_seen = 1'b1;
				end
			end
			ACT_INSTR: begin
				if (track_en) flags_m[a] = flags_at(a) | FL_EXEC | FL_OPCODE;
				cur_instr = a;
			end
			ACT_JUMP: if (track_en) flags_m[a] = flags_at(a) | FL_JUMP;
			ACT_QUERY: begin
				seen = 0;
				for (int i = 0; i < 32; i++)
					if (slot_bits[i]) begin
						if (seen == v && r.slot_base == 0)
							r.slot_base = 16'(SND_LO + i * 32);
						seen++;
					end
			end
			default: ;
		endcase
		r.access_flags = flags_at(a);
		r.writer_address = writer_at(a);
		r.zero_page_count = zp_cnt[a[7:0]];
		r.sound_reg_count = snd_cnt[a[4:0]];
		r.sound_total = snd_total;
		r.zero_page_total = zp_total;
		r.slots_used = 6'($countones(slot_bits));
		r.timer_low = tmr_lo_q;
		r.timer_high = tmr_hi_q;
		r.timer_written = tmr_seen;
		return r;
	endfunction

	task automatic send_event(logic [2:0] act, logic [15:0] a, logic [7:0] v);
		int gap;
		result_t r;
		gap = $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, v, a, act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = track_event(action_t'(act), a, v);
		pending_results = {pending_results, r};
		@(negedge clk);
	endtask

	// output ready driver
	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			gap = $urandom_range(0, 15);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		result_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[188:0]);
			if (pending_results.size() == 0) begin
				$error("result with no transaction pending");
				errors++;
			end else begin
				exp = pending_results.pop_front();
				if (got.access_flags !== exp.access_flags) begin
					$error("access_flags exp %0h got %0h", exp.access_flags, got.access_flags);
					errors++;
				end
				if (got.writer_address !== exp.writer_address) begin
					$error("writer_address exp %0h got %0h", exp.writer_address,
						got.writer_address);
					errors++;
				end
				if (got.zero_page_count !== exp.zero_page_count) begin
					$error("zero_page_count exp %0h got %0h", exp.zero_page_count,
						got.zero_page_count);
					errors++;
				end
				if (got.sound_reg_count !== exp.sound_reg_count) begin
					$error("sound_reg_count exp %0h got %0h", exp.sound_reg_count,
						got.sound_reg_count);
					errors++;
				end
				if (got.sound_total !== exp.sound_total) begin
					$error("sound_total exp %0h got %0h", exp.sound_total, got.sound_total);
					errors++;
				end
				if (got.zero_page_total !== exp.zero_page_total) begin
					$error("zero_page_total exp %0h got %0h", exp.zero_page_total,
						got.zero_page_total);
					errors++;
				end
				if (got.slots_used !== exp.slots_used) begin
					$error("slots_used exp %0h got %0h", exp.slots_used, got.slots_used);
					errors++;
				end
				if (got.slot_base !== exp.slot_base) begin
					$error("slot_base exp %0h got %0h", exp.slot_base, got.slot_base);
					errors++;
				end
				if (got.timer_low !== exp.timer_low) begin
					$error("timer_low exp %0h got %0h", exp.timer_low, got.timer_low);
					errors++;
				end
				if (got.timer_high !== exp.timer_high) begin
					$error("timer_high exp %0h got %0h", exp.timer_high, got.timer_high);
					errors++;
				end
				if (got.timer_written !== exp.timer_written) begin
					$error("timer_written exp %0h got %0h", exp.timer_written,
						got.timer_written);
					errors++;
				end
				if (got.sequence_event !== exp.sequence_event) begin
					$error("sequence_event exp %0h got %0h", exp.sequence_event,
						got.sequence_event);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TRACK) track_en = val;
		else record_en = val;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(0, 7))
			0, 1: return 16'($urandom_range(0, 255));
			2, 3: return 16'($urandom_range(SND_LO, SND_HI));
			4: return 16'($urandom_range(TMR_LO, TMR_HI));
			5: return 16'($urandom_range(16'h1000, 16'h100f));
			default: return 16'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	task automatic test_tracking_off();
		send_event(ACT_READ, 16'h0010, 8'h00);
		send_event(ACT_WRITE, SND_LO, 8'hff);
		send_event(ACT_INSTR, 16'hc000, 8'h00);
		send_event(ACT_JUMP, 16'hffff, 8'h00);
		send_event(ACT_QUERY, 16'h0000, 8'h00);
	endtask

	task automatic test_directed();
		send_event(ACT_INSTR, 16'hffff, 8'h00);
		send_event(ACT_WRITE, 16'h0000, 8'h55);
		send_event(ACT_WRITE, 16'h00ff, 8'haa);
		send_event(ACT_WRITE, SND_LO, 8'h01);
		send_event(ACT_WRITE, SND_HI, 8'h02);
		send_event(ACT_WRITE, TMR_LO, 8'hff);
		send_event(ACT_WRITE, TMR_HI, 8'h00);
		send_event(ACT_READ, 16'hffff, 8'h00);
		send_event(ACT_JUMP, 16'h0000, 8'h00);
		send_event(ACT_QUERY, SND_LO, 8'd0);
		send_event(ACT_QUERY, SND_HI, 8'd1);
		send_event(ACT_QUERY, 16'h00ff, 8'd2);
		send_event(ACT_QUERY, 16'h0000, 8'd255);
		send_event(3'd5, SND_LO, 8'd0);
		send_event(3'd6, 16'h0000, 8'd0);
		send_event(3'd7, 16'hffff, 8'hff);
		send_event(ACT_WRITE, 16'h0100, 8'h00);
	endtask

	task automatic test_random(int n);
		logic [2:0] act;
		for (int i = 0; i < n; i++) begin
			act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_event(act, pick_addr(),
				(act == ACT_QUERY) ? 8'($urandom_range(0, 34)) : 8'($urandom));
		end
	endtask

	initial begin
		slot_bits = '0;
		snd_total = '0;
		zp_total = '0;
		cur_instr = '0;
		tmr_lo_q = '0;
		tmr_hi_q = '0;
		tmr_seen = 1'b0;
		track_en = 1'b0;
		record_en = 1'b0;
		foreach (zp_cnt[i]) zp_cnt[i] = '0;
		foreach (snd_cnt[i]) snd_cnt[i] = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_tracking_off();
		drain();
		write_cfg(CFG_TRACK, 1'b1);
		write_cfg(CFG_RECORD, 1'b1);
		test_directed();
		test_random(220);
		drain();
		write_cfg(CFG_RECORD, 1'b0);
		test_random(220);
		drain();
		write_cfg(CFG_TRACK, 1'b0);
		write_cfg(CFG_RECORD, 1'b1);
		test_random(100);
		drain();
		write_cfg(CFG_TRACK, 1'b1);
		test_random(100);
		drain();
		if (errors == 0) begin
			$display("PASS bus_access_tracker_top");
		end else begin
			$display("FAIL bus_access_tracker_top");
		end
		$finish;
	end
endmodule

### sim.f
design/bat_pkg.sv
design/bat_front.sv
design/bat_back.sv
design/bus_access_tracker_top.sv
tb/sv/tb_top.sv
